/* sv/interval_timer_io_ports_macros.svh */
// Assertion macros for the interval timer and I/O port block.
// Included by the RTL modules that carry concurrent assertions.
`ifndef INTERVAL_TIMER_IO_PORTS_MACROS_SVH
`define INTERVAL_TIMER_IO_PORTS_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ITIO_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ITIO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/itio_pkg.sv */
// Types, codes and constants for the interval timer and I/O port block.
// No dependencies; imported by interval_timer_io_ports and the testbench.
`default_nettype none

package itio_pkg;

   typedef logic [1:0]  cmd_type;
   typedef logic [4:0]  addr_type;
   typedef logic [7:0]  byte_type;
   typedef logic [10:0] prescale_type;
   typedef logic [1:0]  reg_sel_type;

   localparam cmd_type CMD_TICK  = 2'd0;
   localparam cmd_type CMD_READ  = 2'd1;
   localparam cmd_type CMD_WRITE = 2'd2;

   localparam reg_sel_type REG_PA_DATA = 2'd0;
   localparam reg_sel_type REG_PA_DIR  = 2'd1;
   localparam reg_sel_type REG_PB_DATA = 2'd2;
   localparam reg_sel_type REG_PB_DIR  = 2'd3;

   localparam int ADDR_TIMER_RD_BIT = 2;
   localparam int ADDR_TIMER_WR_BIT = 4;
   localparam int ADDR_FLAG_SEL_BIT = 0;

   localparam prescale_type PRESCALE_RESET = 11'd1024;
   localparam byte_type     TIMER_WRAP     = 8'hFF;
   localparam byte_type     FLAG_READ_SET  = 8'h80;

   function automatic prescale_type prescale_of(input reg_sel_type sel);
      prescale_type r;
      case (sel)
         2'd0:    r = 11'd1;
         2'd1:    r = 11'd8;
         2'd2:    r = 11'd64;
         default: r = 11'd1024;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

/* sv/interval_timer_io_ports.sv */
// Interval timer with prescaler plus joystick / console switch ports.
// Depends on itio_pkg and interval_timer_io_ports_macros.svh.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+-------------------------------------------
//   req     | req_valid | req_stall | cmd, reg_addr, write_data, joystick, switches
//   rsp     | rsp_valid | rsp_stall | read_data, timer_flag
//
// One beat per clock sustained while rsp_stall is low; each beat passes through
// the input register, then the result register. Timer state updates as the item
// leaves the input register. req_stall rises only when the input register is full
// and the result register is held by rsp_stall. Synchronous reset clears the timer,
// ports and both valid bits; prescaler comes out of reset at 1024.
`default_nettype none

`include "interval_timer_io_ports_macros.svh"

module interval_timer_io_ports (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire itio_pkg::cmd_type  req_cmd,
   input  wire itio_pkg::addr_type req_reg_addr,
   input  wire itio_pkg::byte_type req_write_data,
   input  wire itio_pkg::byte_type req_joystick_pressed,
   input  wire logic               req_reset_switch,
   input  wire logic               req_select_switch,
   input  wire logic               req_color_mode,
   input  wire logic               req_left_difficulty,
   input  wire logic               req_right_difficulty,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      itio_pkg::byte_type rsp_read_data,
   output      logic               rsp_timer_flag
);
   import itio_pkg::*;

   // input register
   logic     s1_valid_ff;
   cmd_type  s1_cmd_ff;
   addr_type s1_addr_ff;
   byte_type s1_wdata_ff;
   byte_type s1_joy_ff;
   logic     s1_rst_sw_ff, s1_sel_sw_ff, s1_color_ff, s1_ldiff_ff, s1_rdiff_ff;

   // result register
   logic     rsp_valid_ff;
   byte_type rsp_data_ff, rsp_data_in;
   logic     rsp_flag_ff;

   // block state
   byte_type     timer_count_ff, timer_count_in;
   prescale_type prescale_count_ff, prescale_count_in;
   prescale_type prescale_reload_ff, prescale_reload_in;
   logic         fast_count_ff, fast_count_in;
   logic         underflow_ff, underflow_in;
   byte_type     pa_latch_ff, pa_latch_in;
   byte_type     pa_dir_ff, pa_dir_in;
   byte_type     pb_dir_ff, pb_dir_in;

   logic out_free, process, s1_load;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign process   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign s1_load   = req_valid && !req_stall;

   always_comb begin
      timer_count_in     = timer_count_ff;
      prescale_count_in  = prescale_count_ff;
      prescale_reload_in = prescale_reload_ff;
      fast_count_in      = fast_count_ff;
      underflow_in       = underflow_ff;
      pa_latch_in        = pa_latch_ff;
      pa_dir_in          = pa_dir_ff;
      pb_dir_in          = pb_dir_ff;
      rsp_data_in        = '0;
      unique case (s1_cmd_ff)
         CMD_TICK: begin
            if (fast_count_ff) begin
               timer_count_in = timer_count_ff - 8'd1;
            end else if (prescale_count_ff <= 11'd1) begin
               prescale_count_in = prescale_reload_ff;
               if (timer_count_ff == '0) begin
                  timer_count_in = TIMER_WRAP;
                  fast_count_in  = 1'b1;
                  underflow_in   = 1'b1;
               end else begin
                  timer_count_in = timer_count_ff - 8'd1;
               end
            end else begin
               prescale_count_in = prescale_count_ff - 11'd1;
            end
         end
         CMD_READ: begin
            if (s1_addr_ff[ADDR_TIMER_RD_BIT]) begin
               if (s1_addr_ff[ADDR_FLAG_SEL_BIT]) begin
                  rsp_data_in = underflow_ff ? FLAG_READ_SET : '0;
               end else begin
                  rsp_data_in  = timer_count_ff;
                  underflow_in = 1'b0;
               end
            end else begin
               unique case (s1_addr_ff[1:0])
                  REG_PA_DATA: rsp_data_in = (~s1_joy_ff & ~pa_dir_ff) | (pa_latch_ff & pa_dir_ff);
                  REG_PA_DIR:  rsp_data_in = pa_dir_ff;
                  REG_PB_DATA: rsp_data_in = {s1_rdiff_ff, s1_ldiff_ff, 2'b11, s1_color_ff,
                                              1'b1, ~s1_sel_sw_ff, ~s1_rst_sw_ff};
                  default:     rsp_data_in = pb_dir_ff;
               endcase
            end
         end
         CMD_WRITE: begin
            if (s1_addr_ff[ADDR_TIMER_WR_BIT]) begin
               timer_count_in     = s1_wdata_ff;
               prescale_reload_in = prescale_of(s1_addr_ff[1:0]);
               prescale_count_in  = prescale_of(s1_addr_ff[1:0]);
               fast_count_in      = 1'b0;
               underflow_in       = 1'b0;
            end else begin
               unique case (s1_addr_ff[1:0])
                  REG_PA_DATA: pa_latch_in = s1_wdata_ff;
                  REG_PA_DIR:  pa_dir_in   = s1_wdata_ff;
                  REG_PB_DATA: ;
                  default:     pb_dir_in   = s1_wdata_ff;
               endcase
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         timer_count_ff     <= '0;
         prescale_count_ff  <= PRESCALE_RESET;
         prescale_reload_ff <= PRESCALE_RESET;
         fast_count_ff      <= 1'b0;
         underflow_ff       <= 1'b0;
         pa_latch_ff        <= '0;
         pa_dir_ff          <= '0;
         pb_dir_ff          <= '0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= 1'b1;
         end else if (process) begin
            s1_valid_ff <= 1'b0;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (process) begin
            timer_count_ff     <= timer_count_in;
            prescale_count_ff  <= prescale_count_in;
            prescale_reload_ff <= prescale_reload_in;
            fast_count_ff      <= fast_count_in;
            underflow_ff       <= underflow_in;
            pa_latch_ff        <= pa_latch_in;
            pa_dir_ff          <= pa_dir_in;
            pb_dir_ff          <= pb_dir_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_cmd_ff    <= req_cmd;
         s1_addr_ff   <= req_reg_addr;
         s1_wdata_ff  <= req_write_data;
         s1_joy_ff    <= req_joystick_pressed;
         s1_rst_sw_ff <= req_reset_switch;
         s1_sel_sw_ff <= req_select_switch;
         s1_color_ff  <= req_color_mode;
         s1_ldiff_ff  <= req_left_difficulty;
         s1_rdiff_ff  <= req_right_difficulty;
      end
      if (process) begin
         rsp_data_ff <= rsp_data_in;
         rsp_flag_ff <= underflow_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_data_ff;
   assign rsp_timer_flag = rsp_flag_ff;

   `ITIO_ASSERT_NOW(a_stall_needs_item, clock, reset, req_stall,
      s1_valid_ff && rsp_valid_ff, "req_stall without a held beat")
   `ITIO_ASSERT_NEXT(a_process_fills_out, clock, reset, process,
      rsp_valid_ff, "processed beat did not reach result register")
   `ITIO_ASSERT_NOW(a_prescale_range, clock, reset, 1'b1,
      prescale_count_ff != '0 && prescale_count_ff <= PRESCALE_RESET,
      "prescale count out of range")
   `ITIO_ASSERT_NEXT(a_timer_write_clears, clock, reset,
      process && s1_cmd_ff == CMD_WRITE && s1_addr_ff[ADDR_TIMER_WR_BIT],
      !fast_count_ff && !underflow_ff && !rsp_timer_flag,
      "timer write did not clear flag and fast mode")

endmodule

`default_nettype wire

/* verif/testbench.sv */
// Self-checking bench for interval_timer_io_ports: timer, prescaler, port A/B reads and writes.
// Predicts every beat from a local copy of the timer and port state; uses itio_pkg.
// Random gaps on the request side and random rsp_stall on the response side.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import itio_pkg::*;

   localparam cmd_type CMD_NONE   = 2'd3;
   localparam int      IDLE_LIMIT = 1000;
   localparam int      DIRECTED   = 29;
   localparam int      RANDOM_CNT = 900;

   typedef struct {
      cmd_type  cmd;
      addr_type addr;
      byte_type wdata;
      byte_type joy;
      logic     rst_sw;
      logic     sel_sw;
      logic     color;
      logic     ldiff;
      logic     rdiff;
      bit       drain;
   } bus_beat_type;

   typedef struct {
      byte_type data;
      logic     flag;
   } bus_result_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   cmd_type  req_cmd = CMD_TICK;
   addr_type req_reg_addr = '0;
   byte_type req_write_data = '0;
   byte_type req_joystick_pressed = '0;
   logic     req_reset_switch = 1'b0;
   logic     req_select_switch = 1'b0;
   logic     req_color_mode = 1'b0;
   logic     req_left_difficulty = 1'b0;
   logic     req_right_difficulty = 1'b0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   byte_type rsp_read_data;
   logic     rsp_timer_flag;

   // predicted block state
   byte_type     timer_count;
   prescale_type prescale_left;
   prescale_type prescale_reload;
   logic         fast_mode;
   logic         irq_flag;
   byte_type     pa_latch;
   byte_type     pa_dir;
   byte_type     pb_dir;

   bus_beat_type   pending_beats[$];
   bus_result_type expected_results[$];
   bus_beat_type   beat_out;
   bus_result_type want;
   int unsigned send_gap = 0;
   int unsigned stall_left = 0;
   bit          send_calm = 1'b0;
   bit          recv_calm = 1'b0;
   int unsigned idle_cycles = 0;
   int unsigned fail_count = 0;

   interval_timer_io_ports dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd             (req_cmd),
      .req_reg_addr        (req_reg_addr),
      .req_write_data      (req_write_data),
      .req_joystick_pressed(req_joystick_pressed),
      .req_reset_switch    (req_reset_switch),
      .req_select_switch   (req_select_switch),
      .req_color_mode      (req_color_mode),
      .req_left_difficulty (req_left_difficulty),
      .req_right_difficulty(req_right_difficulty),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_read_data       (rsp_read_data),
      .rsp_timer_flag      (rsp_timer_flag)
   );

   always #6 clock = ~clock;

   function automatic bus_result_type timer_port_step(input bus_beat_type b);
      bus_result_type r;
      r.data = '0;
      case (b.cmd)
         CMD_TICK: begin
            if (fast_mode) begin
               timer_count = timer_count - 8'd1;
            end else if (prescale_left <= 11'd1) begin
               prescale_left = prescale_reload;
               if (timer_count == '0) begin
                  timer_count = TIMER_WRAP;
                  fast_mode = 1'b1;
                  irq_flag = 1'b1;
               end else begin
                  timer_count = timer_count - 8'd1;
               end
            end else begin
               prescale_left = prescale_left - 11'd1;
            end
         end
         CMD_READ: begin
            if (b.addr[ADDR_TIMER_RD_BIT]) begin
               if (b.addr[ADDR_FLAG_SEL_BIT]) begin
                  r.data = irq_flag ? FLAG_READ_SET : 8'h00;
               end else begin
                  r.data = timer_count;
                  irq_flag = 1'b0;
               end
            end else begin
               case (reg_sel_type'(b.addr[1:0]))
                  REG_PA_DATA: r.data = (~b.joy & ~pa_dir) | (pa_latch & pa_dir);
                  REG_PA_DIR:  r.data = pa_dir;
                  REG_PB_DATA: begin
                     r.data = 8'hFF;
                     r.data[0] = ~b.rst_sw;
                     r.data[1] = ~b.sel_sw;
                     r.data[3] = b.color;
                     r.data[6] = b.ldiff;
                     r.data[7] = b.rdiff;
                  end
                  default:     r.data = pb_dir;
               endcase
            end
         end
         CMD_WRITE: begin
            if (b.addr[ADDR_TIMER_WR_BIT]) begin
               fast_mode = 1'b0;
               irq_flag = 1'b0;
               timer_count = b.wdata;
               case (reg_sel_type'(b.addr[1:0]))
                  2'd0:    prescale_reload = 11'd1;
                  2'd1:    prescale_reload = 11'd8;
                  2'd2:    prescale_reload = 11'd64;
                  default: prescale_reload = PRESCALE_RESET;
               endcase
               prescale_left = prescale_reload;
            end else begin
               case (reg_sel_type'(b.addr[1:0]))
                  REG_PA_DATA: pa_latch = b.wdata;
                  REG_PA_DIR:  pa_dir = b.wdata;
                  REG_PB_DATA: ;
                  default:     pb_dir = b.wdata;
               endcase
            end
         end
         default: ;
      endcase
      r.flag = irq_flag;
      return r;
   endfunction

   function automatic bus_beat_type make_beat(input cmd_type c, input addr_type a,
                                              input byte_type d);
      bus_beat_type b;
      b.cmd = c;
      b.addr = a;
      b.wdata = d;
      b.joy = byte_type'($urandom);
      b.rst_sw = 1'($urandom_range(0, 1));
      b.sel_sw = 1'($urandom_range(0, 1));
      b.color = 1'($urandom_range(0, 1));
      b.ldiff = 1'($urandom_range(0, 1));
      b.rdiff = 1'($urandom_range(0, 1));
      b.drain = 1'b0;
      return b;
   endfunction

   // mostly back to back, some short pauses, a few long ones
   function automatic int unsigned pause_len(input bit calm);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 72) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(timer_port_step(beat_out));
            if ($urandom_range(0, 149) == 0) send_calm = !send_calm;
            send_gap = pause_len(send_calm);
         end
         if (!(req_valid && req_stall)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_beats.size() > 0 &&
                         !(pending_beats[0].drain && expected_results.size() > 0)) begin
               beat_out = pending_beats.pop_front();
               req_cmd <= beat_out.cmd;
               req_reg_addr <= beat_out.addr;
               req_write_data <= beat_out.wdata;
               req_joystick_pressed <= beat_out.joy;
               req_reset_switch <= beat_out.rst_sw;
               req_select_switch <= beat_out.sel_sw;
               req_color_mode <= beat_out.color;
               req_left_difficulty <= beat_out.ldiff;
               req_right_difficulty <= beat_out.rdiff;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("unexpected beat: read_data %02h timer_flag %0b",
                      rsp_read_data, rsp_timer_flag);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_read_data !== want.data) begin
                  $error("read_data: expected %02h, got %02h", want.data, rsp_read_data);
                  fail_count++;
               end
               if (rsp_timer_flag !== want.flag) begin
                  $error("timer_flag: expected %0b, got %0b", want.flag, rsp_timer_flag);
                  fail_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            if ($urandom_range(0, 199) == 0) recv_calm = !recv_calm;
            stall_left = pause_len(recv_calm);
            rsp_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin : stimulus
      bus_beat_type b;
      addr_type     a;
      reg_sel_type  sel;
      byte_type     d;
      int unsigned  n;
      int unsigned  r;

      timer_count = '0;
      prescale_left = PRESCALE_RESET;
      prescale_reload = PRESCALE_RESET;
      fast_mode = 1'b0;
      irq_flag = 1'b0;
      pa_latch = '0;
      pa_dir = '0;
      pb_dir = '0;

      // console switches, all released then all set
      b = make_beat(CMD_READ, 5'h02, 8'h00);
      {b.rst_sw, b.sel_sw, b.color, b.ldiff, b.rdiff} = '0;
      pending_beats.push_back(b);
      {b.rst_sw, b.sel_sw, b.color, b.ldiff, b.rdiff} = '1;
      pending_beats.push_back(b);
      // port A direction and latch, joystick extremes, ignored address bits
      pending_beats.push_back(make_beat(CMD_WRITE, 5'h01, 8'hF0));
      pending_beats.push_back(make_beat(CMD_WRITE, 5'h00, 8'hA5));
      b = make_beat(CMD_READ, 5'h00, 8'h00);
      b.joy = 8'h00;
      pending_beats.push_back(b);
      b = make_beat(CMD_READ, 5'h08, 8'h00);
      b.joy = 8'hFF;
      pending_beats.push_back(b);
      pending_beats.push_back(make_beat(CMD_READ, 5'h11, 8'h00));
      pending_beats.push_back(make_beat(CMD_WRITE, 5'h03, 8'hFF));
      pending_beats.push_back(make_beat(CMD_READ, 5'h03, 8'h00));
      pending_beats.push_back(make_beat(CMD_WRITE, 5'h02, 8'h55));
      pending_beats.push_back(make_beat(CMD_WRITE, 5'h04, 8'h00));
      pending_beats.push_back(make_beat(CMD_NONE, 5'h1F, 8'hFF));
      // prescale 1 from zero: underflow, fast count, flag read, clear on count read
      b = make_beat(CMD_WRITE, 5'h10, 8'h00);
      b.drain = 1'b1;
      pending_beats.push_back(b);
      pending_beats.push_back(make_beat(CMD_TICK, 5'h00, 8'h00));
      pending_beats.push_back(make_beat(CMD_TICK, 5'h00, 8'h00));
      pending_beats.push_back(make_beat(CMD_READ, 5'h05, 8'h00));
      pending_beats.push_back(make_beat(CMD_READ, 5'h04, 8'h00));
      pending_beats.push_back(make_beat(CMD_READ, 5'h1D, 8'h00));
      pending_beats.push_back(make_beat(CMD_WRITE, 5'h1F, 8'hFF));
      pending_beats.push_back(make_beat(CMD_TICK, 5'h00, 8'h00));
      // prescale 8 from zero: underflow on the eighth tick
      pending_beats.push_back(make_beat(CMD_WRITE, 5'h15, 8'h00));
      repeat (8) pending_beats.push_back(make_beat(CMD_TICK, 5'h00, 8'h00));

      while (pending_beats.size() < DIRECTED + RANDOM_CNT) begin
         r = $urandom_range(0, 9);
         if (r < 6) begin
            // timer load followed by a run of mostly ticks and reads, with some port writes and random commands
            r = $urandom_range(0, 19);
            sel = (r < 8) ? 2'd0 : (r < 15) ? 2'd1 : (r < 19) ? 2'd2 : 2'd3;
            a = addr_type'($urandom);
            a[ADDR_TIMER_WR_BIT] = 1'b1;
            a[1:0] = sel;
            d = ($urandom_range(0, 3) != 0) ? byte_type'($urandom_range(0, 12))
                                             : byte_type'($urandom);
            b = make_beat(CMD_WRITE, a, d);
            b.drain = ($urandom_range(0, 99) < 3);
            pending_beats.push_back(b);
            n = $urandom_range(4, 40);
            repeat (n) begin
               r = $urandom_range(0, 99);
               a = addr_type'($urandom);
               if (r < 65) begin
                  pending_beats.push_back(make_beat(CMD_TICK, a, byte_type'($urandom)));
               end else if (r < 85) begin
                  a[ADDR_TIMER_RD_BIT] = 1'b1;
                  pending_beats.push_back(make_beat(CMD_READ, a, byte_type'($urandom)));
               end else if (r < 92) begin
                  a[ADDR_TIMER_RD_BIT] = 1'b0;
                  pending_beats.push_back(make_beat(CMD_READ, a, byte_type'($urandom)));
               end else if (r < 96) begin
                  a[ADDR_TIMER_WR_BIT] = 1'b0;
                  pending_beats.push_back(make_beat(CMD_WRITE, a, byte_type'($urandom)));
               end else begin
                  pending_beats.push_back(make_beat(cmd_type'($urandom_range(0, 3)), a,
                                                    byte_type'($urandom)));
               end
            end
         end else if (r < 9) begin
            // port traffic
            repeat (10) begin
               a = addr_type'($urandom);
               if ($urandom_range(0, 1) != 0) begin
                  a[ADDR_TIMER_WR_BIT] = 1'b0;
                  pending_beats.push_back(make_beat(CMD_WRITE, a, byte_type'($urandom)));
               end else begin
                  a[ADDR_TIMER_RD_BIT] = 1'b0;
                  pending_beats.push_back(make_beat(CMD_READ, a, byte_type'($urandom)));
               end
            end
         end else begin
            repeat (8) pending_beats.push_back(make_beat(cmd_type'($urandom_range(0, 3)),
                                                         addr_type'($urandom),
                                                         byte_type'($urandom)));
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_beats.size() > 0 || req_valid) @(posedge clock);
      while (expected_results.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
